FILE: hdl/sca_pkg.sv
package sca_pkg;

   localparam int PAGE_BYTES        = 4096;
   localparam int HEAP_WORDS        = 262144;
   localparam int NUM_CLASSES       = 11;
   localparam int MIN_CELL_BYTES    = 8;
   localparam int HEADER_BYTES      = 4;
   localparam int MAX_BLOCK_PAGES   = 256;
   localparam int FIRST_BLOCK_PAGES = 4;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 24;
   localparam int PAGE_CNT_W = 9;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;

   localparam int HEAP_AW     = $clog2(HEAP_WORDS);
   localparam int PAGE_LG     = $clog2(PAGE_BYTES);
   localparam int MIN_LG      = $clog2(MIN_CELL_BYTES);
   localparam int CLS_W       = $clog2(NUM_CLASSES);
   localparam int BP_W        = $clog2(MAX_BLOCK_PAGES + 1);
   localparam int LG_W        = $clog2(SIZE_W + 2);
   localparam int LIMIT_PAGES = (HEAP_WORDS * 4) / PAGE_BYTES;

   localparam int REQ_DATA_W = ((SIZE_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + 7) / 8) * 8;

   localparam logic [ADDR_W-1:0]     HEAP_BASE_RESET  = ADDR_W'(4096);
   localparam logic [PAGE_CNT_W-1:0] HEAP_PAGES_RESET = PAGE_CNT_W'(256);
   localparam logic [ADDR_W-1:0]     LIST_END         = {ADDR_W{1'b1}};

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE         = 3'd0,
      ST_NO_PAGES     = 3'd1,
      ST_SIZE_ZERO    = 3'd2,
      ST_TOO_LARGE    = 3'd3,
      ST_NULL_FREE    = 3'd4,
      ST_ALIGNED_FREE = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_PAGES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       clear_wr;
      logic       load_req;
      logic       decode;
      logic       refill;
      logic       tail_wr;
      logic       head_rd;
      logic       pop;
      logic       free_rd;
      logic       free_wr;
      logic       set_status;
      status_type status_code;
      logic       load_rsp;
   } sca_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic size_zero;
      logic too_large;
      logic null_free;
      logic aligned_free;
      logic head_empty;
      logic refill_fail;
   } sca_stat_type;

endpackage

FILE: hdl/sca_ram.sv
module sca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/sca_ctrl.sv
module sca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sca_pkg::sca_stat_type stat,
   output sca_pkg::sca_cmd_type  cmd
);

   import sca_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR      = 11'b00000000001,
      S_IDLE       = 11'b00000000010,
      S_DECODE     = 11'b00000000100,
      S_DISPATCH   = 11'b00000001000,
      S_REFILL     = 11'b00000010000,
      S_TAIL       = 11'b00000100000,
      S_READ       = 11'b00001000000,
      S_POP        = 11'b00010000000,
      S_FREE_READ  = 11'b00100000000,
      S_FREE_WRITE = 11'b01000000000,
      S_DONE       = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_DONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (stat.is_free) begin
               if (stat.null_free) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NULL_FREE;
                  state_in        = S_DONE;
               end else if (stat.aligned_free) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_ALIGNED_FREE;
                  state_in        = S_DONE;
               end else begin
                  state_in = S_FREE_READ;
               end
            end else begin
               if (stat.size_zero) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_SIZE_ZERO;
                  state_in        = S_DONE;
               end else if (stat.too_large) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_TOO_LARGE;
                  state_in        = S_DONE;
               end else if (stat.head_empty) begin
                  state_in = S_REFILL;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_REFILL: begin
            cmd.refill = 1'b1;
            if (stat.refill_fail) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NO_PAGES;
               state_in        = S_DONE;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cmd.tail_wr = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.head_rd = 1'b1;
            state_in    = S_POP;
         end
         S_POP: begin
            cmd.pop         = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_in        = S_DONE;
         end
         S_FREE_READ: begin
            cmd.free_rd = 1'b1;
            state_in    = S_FREE_WRITE;
         end
         S_FREE_WRITE: begin
            cmd.free_wr     = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/sca_dpath.sv
module sca_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  sca_pkg::sca_cmd_type               cmd,
   output sca_pkg::sca_stat_type              stat,
   input  logic                               req_opcode,
   input  logic [sca_pkg::SIZE_W-1:0]         req_bytes,
   input  logic [sca_pkg::ADDR_W-1:0]         req_user,
   input  logic                               csr_wr_en,
   input  logic [sca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sca_pkg::ADDR_W-1:0]         csr_data,
   output logic [sca_pkg::ADDR_W-1:0]         rsp_address,
   output logic [sca_pkg::STATUS_W-1:0]       rsp_status
);

   import sca_pkg::*;

   logic [ADDR_W-1:0]     heap_base_ff;
   logic [PAGE_CNT_W-1:0] heap_pages_ff;

   opcode_type            opcode_ff;
   logic [SIZE_W-1:0]     bytes_ff;
   logic [ADDR_W-1:0]     user_ff;

   logic [CLS_W-1:0]      cls_ff;
   logic                  size_zero_ff;
   logic                  too_large_ff;
   logic                  null_free_ff;
   logic                  aligned_free_ff;
   logic [ADDR_W-1:0]     hdr_ff;

   logic [ADDR_W-1:0]     head_ff [NUM_CLASSES];
   logic [BP_W-1:0]       pages_ff [NUM_CLASSES];
   logic [PAGE_CNT_W-1:0] nfp_ff;

   logic [HEAP_AW-1:0]    tail_idx_ff;
   logic                  tail_ok_ff;
   logic [HEAP_AW-1:0]    acc_idx_ff;
   logic                  acc_ok_ff;
   logic [ADDR_W-1:0]     h_ff;
   logic [HEAP_AW-1:0]    clear_idx_ff;

   logic [ADDR_W-1:0]     res_addr_ff;
   status_type            res_status_ff;
   logic [ADDR_W-1:0]     rsp_address_ff;
   status_type            rsp_status_ff;

   logic [SIZE_W:0]       size_m1;
   logic [LG_W-1:0]       lg;
   logic [LG_W-1:0]       cls_full;
   logic                  too_large;

   logic [ADDR_W-1:0]     rd_word;
   logic                  c_ok;
   logic [CLS_W-1:0]      hsel;
   logic [ADDR_W-1:0]     head_cur;
   logic [ADDR_W-1:0]     cell_size;

   logic [BP_W-1:0]       psize;
   logic [BP_W:0]         psize_x2;
   logic [ADDR_W-1:0]     avail;
   logic [ADDR_W-1:0]     need;
   logic [ADDR_W-1:0]     nfp_off;
   logic [ADDR_W-1:0]     block_bytes;
   logic [ADDR_W-1:0]     tail_off;
   logic                  refill_fail;

   logic [ADDR_W-1:0]     acc_addr;
   logic [ADDR_W-1:0]     acc_off;

   logic                  ram_en;
   logic                  ram_we;
   logic [HEAP_AW-1:0]    ram_addr;
   logic [ADDR_W-1:0]     ram_wdata;
   logic [ADDR_W-1:0]     ram_rdata;

   always_comb begin
      size_m1 = {1'b0, bytes_ff} + (SIZE_W + 1)'(HEADER_BYTES - 1);
      lg      = '0;
      for (int i = 0; i < SIZE_W + 1; i++) begin
         if (size_m1[i]) begin
            lg = LG_W'(i + 1);
         end
      end
      if (lg <= LG_W'(MIN_LG)) begin
         cls_full = '0;
      end else begin
         cls_full = lg - LG_W'(MIN_LG);
      end
      too_large = (cls_full >= LG_W'(NUM_CLASSES));
   end

   assign rd_word   = acc_ok_ff ? ram_rdata : '0;
   assign c_ok      = (rd_word < ADDR_W'(NUM_CLASSES));
   assign hsel      = (cmd.free_wr && c_ok) ? rd_word[CLS_W-1:0] : cls_ff;
   assign head_cur  = head_ff[hsel];
   assign cell_size = ADDR_W'(MIN_CELL_BYTES) << cls_ff;

   always_comb begin
      psize       = pages_ff[cls_ff];
      psize_x2    = {1'b0, psize} << 1;
      avail       = (ADDR_W'(heap_pages_ff) > ADDR_W'(LIMIT_PAGES)) ?
                    ADDR_W'(LIMIT_PAGES) : ADDR_W'(heap_pages_ff);
      need        = ADDR_W'(nfp_ff) + ADDR_W'(psize);
      nfp_off     = ADDR_W'(nfp_ff) << PAGE_LG;
      block_bytes = ADDR_W'(psize) << PAGE_LG;
      tail_off    = nfp_off + block_bytes - cell_size;
      refill_fail = (need > avail) || (cell_size > block_bytes);
   end

   assign acc_addr = cmd.free_rd ? hdr_ff : head_cur;
   assign acc_off  = acc_addr - heap_base_ff;

   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = acc_off[HEAP_AW+1:2];
      ram_wdata = '0;
      if (cmd.clear_wr) begin
         ram_en   = 1'b1;
         ram_we   = 1'b1;
         ram_addr = clear_idx_ff;
      end else if (cmd.tail_wr) begin
         ram_en    = tail_ok_ff;
         ram_we    = 1'b1;
         ram_addr  = tail_idx_ff;
         ram_wdata = LIST_END;
      end else if (cmd.head_rd || cmd.free_rd) begin
         ram_en = (acc_off[ADDR_W-1:HEAP_AW+2] == '0);
      end else if (cmd.pop) begin
         ram_en    = acc_ok_ff;
         ram_we    = 1'b1;
         ram_addr  = acc_idx_ff;
         ram_wdata = ADDR_W'(cls_ff);
      end else if (cmd.free_wr) begin
         ram_en    = acc_ok_ff && c_ok;
         ram_we    = 1'b1;
         ram_addr  = acc_idx_ff;
         ram_wdata = head_cur;
      end
   end

   sca_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (HEAP_WORDS)
   ) u_heap (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= HEAP_BASE_RESET;
         heap_pages_ff <= HEAP_PAGES_RESET;
         nfp_ff        <= '0;
         clear_idx_ff  <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= LIST_END;
            pages_ff[i] <= BP_W'(FIRST_BLOCK_PAGES);
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEAP_BASE:  heap_base_ff  <= csr_data;
               CSR_HEAP_PAGES: heap_pages_ff <= csr_data[PAGE_CNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.clear_wr) begin
            clear_idx_ff <= clear_idx_ff + HEAP_AW'(1);
         end
         if (cmd.refill) begin
            if (psize < BP_W'(MAX_BLOCK_PAGES)) begin
               if (psize_x2 > (BP_W + 1)'(MAX_BLOCK_PAGES)) begin
                  pages_ff[cls_ff] <= BP_W'(MAX_BLOCK_PAGES);
               end else begin
                  pages_ff[cls_ff] <= psize_x2[BP_W-1:0];
               end
            end
            if (!refill_fail) begin
               nfp_ff          <= need[PAGE_CNT_W-1:0];
               head_ff[cls_ff] <= heap_base_ff + nfp_off;
            end
         end
         if (cmd.pop) begin
            head_ff[cls_ff] <= (rd_word == '0) ? h_ff + cell_size : rd_word;
         end
         if (cmd.free_wr && c_ok) begin
            head_ff[hsel] <= hdr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         opcode_ff   <= opcode_type'(req_opcode);
         bytes_ff    <= req_bytes;
         user_ff     <= req_user;
         res_addr_ff <= '0;
      end
      if (cmd.decode) begin
         cls_ff          <= too_large ? '0 : cls_full[CLS_W-1:0];
         size_zero_ff    <= (bytes_ff == '0);
         too_large_ff    <= too_large;
         null_free_ff    <= (user_ff == '0);
         aligned_free_ff <= (user_ff[PAGE_LG-1:0] == '0);
         hdr_ff          <= user_ff - ADDR_W'(HEADER_BYTES);
      end
      if (cmd.refill) begin
         tail_idx_ff <= tail_off[HEAP_AW+1:2];
         tail_ok_ff  <= (tail_off[ADDR_W-1:HEAP_AW+2] == '0);
      end
      if (cmd.head_rd || cmd.free_rd) begin
         acc_idx_ff <= acc_off[HEAP_AW+1:2];
         acc_ok_ff  <= (acc_off[ADDR_W-1:HEAP_AW+2] == '0);
         h_ff       <= acc_addr;
      end
      if (cmd.pop) begin
         res_addr_ff <= h_ff + ADDR_W'(HEADER_BYTES);
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
      if (cmd.load_rsp) begin
         rsp_address_ff <= res_addr_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   always_comb begin
      stat              = '0;
      stat.clear_last   = (clear_idx_ff == HEAP_AW'(HEAP_WORDS - 1));
      stat.is_free      = (opcode_ff == OP_FREE);
      stat.size_zero    = size_zero_ff;
      stat.too_large    = too_large_ff;
      stat.null_free    = null_free_ff;
      stat.aligned_free = aligned_free_ff;
      stat.head_empty   = (head_cur == LIST_END);
      stat.refill_fail  = refill_fail;
   end

   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

FILE: hdl/size_class_cell_allocator_core.sv
// Cell allocator with power-of-two size classes whose free lists live in the heap words. After
// reset the heap memory is swept to zero, one word a cycle, which keeps req_tready low until
// the sweep ends; configuration writes are taken during the sweep as at any time. Requests are
// handled one at a time by a sequencer around the single-port heap memory: an allocate served
// from a free list reads its head cell and pops it; one that refills its class first takes a
// block from the page supply and marks its last cell; a free reads the cell header and pushes
// the cell back on its class list; a request rejected by size or address goes to the result.
// The result sits in an output register, so the next request is accepted while it waits.
module size_class_cell_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: request_bytes, user_address.
   input  logic [sca_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Fields from bit 0 up: opcode.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: result_address.
   output logic [sca_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Fields from bit 0 up: status.
   output logic [sca_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [sca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sca_pkg::ADDR_W-1:0]          csr_data
);

   import sca_pkg::*;

   sca_cmd_type       cmd;
   sca_stat_type      stat;
   logic [ADDR_W-1:0] rsp_address;

   sca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sca_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_opcode  (req_tuser),
      .req_bytes   (req_tdata[SIZE_W-1:0]),
      .req_user    (req_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_address (rsp_address),
      .rsp_status  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_address);

endmodule

FILE: hdl/sca_checker.sv
module sca_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sca_pkg::STATUS_W-1:0]   rsp_tuser
);

   import sca_pkg::*;

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The heap sweep after reset keeps the request side closed.
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted during the heap sweep");

   // Requests are handled one at a time, so a transfer never follows in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // Only a completed allocate carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != '0) |-> rsp_tuser == ST_DONE)
      else $error("address given with a failure status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DONE) |-> rsp_tdata == '0)
      else $error("failure status with a nonzero address");

endmodule

bind size_class_cell_allocator_core sca_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
